/* rtl/core/psnds_pkg.sv */
`default_nettype none
package psnds_pkg;
   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_QUERY  = 2'd1;
   localparam logic [1:0] OP_FINISH = 2'd2;
   localparam logic [1:0] OP_CLEAR  = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_REF   = 2'd1;
   localparam logic [1:0] ST_NO_QUERY = 2'd2;
   localparam logic [1:0] ST_OVERFLOW = 2'd3;

   localparam int DIST_BITS = 21;
   localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

   typedef struct packed {
      logic        start;
      logic [63:0] value;
   } root_req_type;
endpackage
`default_nettype wire

/* rtl/core/point_set_nearest_distance_stats.sv */
`default_nettype none
// Channel | Direction | tdata fields (low bit up)               | tuser
// req     | in        | point_x, point_y, point_z (60 bits)       | operation
// rsp     | out       | min, max, mean, std_dev, near_query xyz,  | status
//         |           | near_ref xyz, query_count                 |
// Load and clear complete in the cycle in which they are accepted. A query against N
// stored points makes one store read per cycle through a three-stage compare, then a
// 32-step root, or skips both with an empty store. A finish runs two 58-step divisions
// and a root, or skips them when no query was seen. Reset is synchronous and
// clears all counters and statistics; the store itself is not cleared. A finish waits
// in its last cycle while the previous word on rsp is still not taken.
module point_set_nearest_distance_stats #(
   parameter int REF_POINTS = 1024,
   parameter int COORD_BITS = 20,
   parameter int COUNT_BITS = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [63:0]  req_tdata,  // point_x, point_y, point_z
   input  wire logic [1:0]   req_tuser,  // operation
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [223:0]      rsp_tdata,  // min, max, mean, std, qx,qy,qz, rx,ry,rz, count
   output logic [1:0]        rsp_tuser   // status
);
   localparam int AW = $clog2(REF_POINTS);
   localparam int CW = AW + 1;
   localparam logic [CW-1:0] REF_FULL = CW'(REF_POINTS);
   localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

   localparam logic [3:0] S_IDLE = 4'd0, S_SCAN = 4'd1, S_SQ = 4'd2, S_ROOT = 4'd3,
      S_UPD = 4'd4, S_DIV1 = 4'd5, S_DIV2 = 4'd6, S_M2 = 4'd7, S_SDR = 4'd8,
      S_OUT = 4'd9;

   logic [3:0] state_ff;
   logic [59:0] mem [REF_POINTS];
   logic [59:0] rd_ff;
   logic [CW-1:0] cnt_ff, idx_ff;
   logic ovf_ff;
   logic [20:0] min_ff, max_ff;
   logic [59:0] pq_ff, pr_ff, q_ff, best_ff, cand_ff;
   logic [36:0] sum_ff;
   logic [57:0] sqs_ff;
   logic [COUNT_BITS-1:0] seen_ff;
   logic [63:0] bsq_ff;
   logic first_ff, rdv_ff, sv_ff;
   logic [20:0] dist_ff;
   logic [63:0] sx_ff, sy_ff, sz_ff;
   logic [57:0] mean_ff, ms_ff;
   logic [63:0] m2_ff;
   logic rv_ff;
   logic [223:0] rd_out_ff;
   logic [1:0] rs_ff;

   function automatic logic [19:0] ext(input logic [19:0] r);
      logic [19:0] m;
      m = r;
      for (int b = 0; b < 20; b++) if (b >= COORD_BITS) m[b] = r[COORD_BITS-1];
      return m;
   endfunction

   function automatic logic signed [20:0] crd(input logic [19:0] r);
      logic [19:0] m;
      m = ext(r);
      return {m[19], m};
   endfunction

   function automatic logic [63:0] sqd(input logic [19:0] a, input logic [19:0] b);
      logic signed [21:0] d;
      logic [20:0] u;
      logic [41:0] p;
      d = 22'(crd(a)) - 22'(crd(b));
      u = d[21] ? 21'(-d) : 21'(d);
      p = u * u;
      return 64'(p);
   endfunction

   psnds_pkg::root_req_type rt;
   logic rbusy;
   logic [31:0] root;
   logic dstart, dbusy;
   logic [57:0] dnum, dq;

   psnds_isqrt u_root (.clock, .reset, .ctrl(rt), .busy(rbusy), .root);
   psnds_divider u_div (.clock, .reset, .start(dstart), .dividend(dnum),
      .divisor(16'(seen_ff)), .busy(dbusy), .quotient(dq));

   logic acc;
   logic out_load;
   logic [59:0] pin;
   assign req_tready = (state_ff == S_IDLE);
   assign acc = req_tvalid && req_tready;
   assign pin = {req_tdata[59:40], req_tdata[39:20], req_tdata[19:0]};
   assign out_load = (state_ff == S_OUT) && (!rv_ff || rsp_tready);

   always_comb begin
      rt.start = 1'b0;
      rt.value = bsq_ff;
      dstart = 1'b0;
      dnum = 58'(sum_ff);
      if (state_ff == S_SQ) rt.start = 1'b1;
      if (state_ff == S_M2) begin
         rt.start = 1'b1;
         rt.value = (64'(ms_ff) > m2_ff) ? 64'(ms_ff) - m2_ff : 64'd0;
      end
      if (state_ff == S_IDLE && acc && req_tuser == psnds_pkg::OP_FINISH
          && seen_ff != '0) dstart = 1'b1;
      if (state_ff == S_DIV1 && !dbusy && !first_ff) begin
         dstart = 1'b1;
         dnum = sqs_ff;
      end
   end

   logic [63:0] ssum;
   assign ssum = sx_ff + sy_ff + sz_ff;

   always_ff @(posedge clock) begin
      if (acc && req_tuser == psnds_pkg::OP_LOAD && cnt_ff < REF_FULL)
         mem[cnt_ff[AW-1:0]] <= pin;
      rd_ff <= mem[idx_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) rv_ff <= 1'b0;
      else if (out_load) rv_ff <= 1'b1;
      else if (rsp_tready) rv_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         ovf_ff <= 1'b0;
         min_ff <= psnds_pkg::DIST_MAX;
         max_ff <= '0;
         pq_ff <= '0;
         pr_ff <= '0;
         sum_ff <= '0;
         sqs_ff <= '0;
         seen_ff <= '0;
         idx_ff <= '0;
         rdv_ff <= 1'b0;
         sv_ff <= 1'b0;
         first_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: if (acc) begin
               q_ff <= pin;
               case (req_tuser)
                  psnds_pkg::OP_LOAD:
                     if (cnt_ff < REF_FULL) cnt_ff <= cnt_ff + 1'b1;
                     else ovf_ff <= 1'b1;
                  psnds_pkg::OP_CLEAR: begin
                     cnt_ff <= '0;
                     ovf_ff <= 1'b0;
                  end
                  psnds_pkg::OP_QUERY: begin
                     best_ff <= '0;
                     bsq_ff <= '0;
                     first_ff <= 1'b1;
                     dist_ff <= psnds_pkg::DIST_MAX;
                     idx_ff <= '0;
                     rdv_ff <= 1'b0;
                     sv_ff <= 1'b0;
                     state_ff <= (cnt_ff == '0) ? S_UPD : S_SCAN;
                  end
                  default: begin
                     mean_ff <= '0;
                     ms_ff <= '0;
                     first_ff <= 1'b1;
                     state_ff <= (seen_ff == '0) ? S_OUT : S_DIV1;
                  end
               endcase
            end
            S_SCAN: begin
               // Address, read data and squared distances form a three-stage pipeline.
               rdv_ff <= idx_ff < cnt_ff;
               if (idx_ff < cnt_ff) idx_ff <= idx_ff + 1'b1;
               sv_ff <= rdv_ff;
               if (rdv_ff) begin
                  sx_ff <= sqd(q_ff[19:0], rd_ff[19:0]);
                  sy_ff <= sqd(q_ff[39:20], rd_ff[39:20]);
                  sz_ff <= sqd(q_ff[59:40], rd_ff[59:40]);
                  cand_ff <= rd_ff;
               end
               if (sv_ff) begin
                  if (first_ff || ssum < bsq_ff) begin
                     bsq_ff <= ssum;
                     best_ff <= cand_ff;
                  end
                  first_ff <= 1'b0;
               end
               if (idx_ff >= cnt_ff && !rdv_ff && !sv_ff) state_ff <= S_SQ;
            end
            S_SQ: state_ff <= S_ROOT;
            S_ROOT: if (!rbusy) begin
               dist_ff <= (root > 32'(psnds_pkg::DIST_MAX)) ? psnds_pkg::DIST_MAX
                          : root[20:0];
               state_ff <= S_UPD;
            end
            S_UPD: begin
               if (dist_ff < min_ff) begin
                  min_ff <= dist_ff;
                  pq_ff <= {ext(q_ff[59:40]), ext(q_ff[39:20]), ext(q_ff[19:0])};
                  pr_ff <= {ext(best_ff[59:40]), ext(best_ff[39:20]), ext(best_ff[19:0])};
               end
               if (dist_ff > max_ff) max_ff <= dist_ff;
               if (seen_ff < CNT_MAX) begin
                  sum_ff <= sum_ff + 37'(dist_ff);
                  sqs_ff <= sqs_ff + 58'(42'(dist_ff) * 42'(dist_ff));
                  seen_ff <= seen_ff + 1'b1;
               end
               state_ff <= S_IDLE;
            end
            S_DIV1: if (!dbusy) begin
               if (first_ff) begin
                  first_ff <= 1'b0;
               end else begin
                  mean_ff <= dq;
                  state_ff <= S_DIV2;
               end
            end
            S_DIV2: if (!dbusy) begin
               ms_ff <= dq;
               m2_ff <= 64'(mean_ff[31:0]) * 64'(mean_ff[31:0]);
               state_ff <= S_M2;
            end
            S_M2: state_ff <= S_SDR;
            S_SDR: if (!rbusy) state_ff <= S_OUT;
            S_OUT: if (out_load) begin
               rs_ff <= ovf_ff ? psnds_pkg::ST_OVERFLOW
                      : (cnt_ff == '0) ? psnds_pkg::ST_NO_REF
                      : (seen_ff == '0) ? psnds_pkg::ST_NO_QUERY : psnds_pkg::ST_OK;
               rd_out_ff <= {4'd0, 16'(seen_ff), pr_ff, pq_ff,
                  (seen_ff == '0) ? 21'd0 : root[20:0], mean_ff[20:0], max_ff, min_ff};
               min_ff <= psnds_pkg::DIST_MAX;
               max_ff <= '0;
               pq_ff <= '0;
               pr_ff <= '0;
               sum_ff <= '0;
               sqs_ff <= '0;
               seen_ff <= '0;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata = rd_out_ff;
   assign rsp_tuser = rs_ff;
endmodule
`default_nettype wire

/* rtl/core/psnds_isqrt.sv */
`default_nettype none
// Iterative square root, one result bit per cycle.
module psnds_isqrt (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire psnds_pkg::root_req_type ctrl,
   output logic                         busy,
   output logic [31:0]                  root
);
   logic [63:0] rem_ff, rem_in;
   logic [31:0] res_ff, res_in;
   logic [32:0] part_ff, part_in;
   logic [5:0]  step_ff, step_in;
   logic        busy_ff, busy_in;
   logic [34:0] trial;
   logic [34:0] cand;

   // The radicand is shifted out two bits at a time from the top.
   always_comb begin
      rem_in = rem_ff;
      res_in = res_ff;
      part_in = part_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      trial = {1'b0, res_ff, 2'b01};
      cand = {part_ff, rem_ff[63:62]};
      if (ctrl.start) begin
         rem_in = ctrl.value;
         res_in = '0;
         part_in = '0;
         step_in = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = {rem_ff[61:0], 2'b00};
         if (cand >= trial) begin
            part_in = 33'(cand - trial);
            res_in = {res_ff[30:0], 1'b1};
         end else begin
            part_in = cand[32:0];
            res_in = {res_ff[30:0], 1'b0};
         end
         step_in = step_ff - 6'd1;
         if (step_ff == 6'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      res_ff <= res_in;
      part_ff <= part_in;
   end

   assign busy = busy_ff;
   assign root = res_ff;
endmodule
`default_nettype wire

/* rtl/core/psnds_divider.sv */
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module psnds_divider (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [57:0] dividend,
   input  wire logic [15:0] divisor,
   output logic             busy,
   output logic [57:0]      quotient
);
   logic [57:0] q_ff, q_in;
   logic [16:0] r_ff, r_in;
   logic [15:0] d_ff;
   logic [5:0]  n_ff, n_in;
   logic        busy_ff, busy_in;
   logic [16:0] sh;

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      n_in = n_ff;
      busy_in = busy_ff;
      sh = '0;
      if (start) begin
         q_in = dividend;
         r_in = '0;
         n_in = 6'd58;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         sh = {r_ff[15:0], q_ff[57]};
         if (sh >= {1'b0, d_ff}) begin
            r_in = sh - {1'b0, d_ff};
            q_in = {q_ff[56:0], 1'b1};
         end else begin
            r_in = sh;
            q_in = {q_ff[56:0], 1'b0};
         end
         n_in = n_ff - 6'd1;
         if (n_ff == 6'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         n_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         n_ff <= n_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      if (start) d_ff <= divisor;
   end

   assign busy = busy_ff;
   assign quotient = q_ff;
endmodule
`default_nettype wire

/* rtl/core/psnds_checker.sv */
`default_nettype none
module psnds_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tvalid,
   input wire logic         req_tready,
   input wire logic [1:0]   req_tuser,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [223:0] rsp_tdata
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");
   a_idle_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_tvalid) else $error("result word present after reset");
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == psnds_pkg::OP_QUERY |=> !req_tready)
      else $error("query did not occupy the block");
   a_only_finish: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser != psnds_pkg::OP_FINISH |=> !$rose(rsp_tvalid))
      else $error("result without finish");
endmodule

bind point_set_nearest_distance_stats psnds_checker u_checker (.*);
`default_nettype wire
